// File: design/cwc_pkg.sv
// shared types and constants of the color window classifier
package cwc_pkg;

    localparam int IDX_W      = 4;
    localparam int TOL_W      = 8;
    localparam int PERIOD_W   = 16;
    localparam int CFG_ADDR_W = 1;

    localparam logic [TOL_W-1:0] COLOR_TOL_RESET = 8'd5;
    localparam logic [TOL_W-1:0] WHITE_TOL_RESET = 8'd2;

    typedef enum logic [0:0] {
        CMD_CLASSIFY  = 1'b0,
        CMD_CALIBRATE = 1'b1
    } cwc_cmd_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_COLOR_TOL = 1'b0,
        CFG_WHITE_TOL = 1'b1
    } cwc_cfg_addr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PARK
    } cwc_state_t;

    // request token walking down the row of entry cells
    typedef struct packed {
        logic             active;
        cwc_cmd_t         command;
        logic [IDX_W-1:0] entry_index;
        logic             found;
        logic [IDX_W-1:0] match_index;
        logic             stored;
    } cwc_token_t;

endpackage

// File: design/cwc_if.sv
// request, result and register write channels of the color window classifier
interface cwc_item_if
    import cwc_pkg::*;
();
    logic                valid;
    logic                ready;
    cwc_cmd_t            command;
    logic [IDX_W-1:0]    entry_index;
    logic [PERIOD_W-1:0] red_period;
    logic [PERIOD_W-1:0] blue_period;
    logic [PERIOD_W-1:0] green_period;
    logic [PERIOD_W-1:0] white_period;

    modport source (output valid, command, entry_index, red_period, blue_period,
                    green_period, white_period, input ready);
    modport sink   (input valid, command, entry_index, red_period, blue_period,
                    green_period, white_period, output ready);
endinterface

interface cwc_result_if
    import cwc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             match_found;
    logic [IDX_W-1:0] match_index;
    logic             stored;

    modport source (output valid, match_found, match_index, stored, input ready);
    modport sink   (input valid, match_found, match_index, stored, output ready);
endinterface

interface cwc_cfg_if
    import cwc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] index;
    logic [TOL_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/cwc_cell.sv
// one calibration entry: stores its periods and checks passing requests
module cwc_cell
    import cwc_pkg::*;
#(
    parameter int CELL_INDEX  = 0,
    parameter int PERIOD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [TOL_W-1:0]              color_tol,
    input  logic [TOL_W-1:0]              white_tol,
    input  cwc_token_t                    tok_in,
    input  logic [3:0][PERIOD_BITS-1:0]   per_in,
    output cwc_token_t                    tok_out,
    output logic [3:0][PERIOD_BITS-1:0]   per_out
);

    localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(CELL_INDEX);

    logic [3:0][PERIOD_BITS-1:0] entry_reg;
    logic                        valid_reg;
    cwc_token_t                  tok_reg;
    cwc_token_t                  tok_next;
    logic [3:0][PERIOD_BITS-1:0] per_reg;
    logic [3:0]                  near;
    logic                        hit_cal;
    logic                        hit_match;

    // strict window test per channel, last one is the unfiltered period
    always_comb
    begin
        logic [PERIOD_BITS-1:0] diff;
        logic [PERIOD_BITS-1:0] tol;
        for (int k = 0; k < 4; k++)
        begin
            diff = (entry_reg[k] > per_in[k]) ? entry_reg[k] - per_in[k]
                                              : per_in[k] - entry_reg[k];
            tol  = (k == 3) ? PERIOD_BITS'(white_tol) : PERIOD_BITS'(color_tol);
            near[k] = diff < tol;
        end
    end

    assign hit_cal   = tok_in.active && (tok_in.command == CMD_CALIBRATE)
                       && (tok_in.entry_index == MY_INDEX);
    assign hit_match = tok_in.active && (tok_in.command == CMD_CLASSIFY)
                       && !tok_in.found && valid_reg && (&near);

    always_comb
    begin
        tok_next = tok_in;
        if (hit_match)
        begin
            tok_next.found       = 1'b1;
            tok_next.match_index = MY_INDEX;
        end
        if (hit_cal)
        begin
            tok_next.stored = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            if (hit_cal)
            begin
                valid_reg <= 1'b1;
            end
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_cal)
        begin
            entry_reg <= per_in;
        end
        per_reg <= per_in;
    end

    assign tok_out = tok_reg;
    assign per_out = per_reg;

endmodule

// File: design/color_window_classifier.sv
// top level of the color window classifier
// A request carries four measured light periods (red, blue, green, unfiltered)
// and a command. Calibrate writes the periods into the entry named by
// entry_index and marks it valid (indexes at or above NUM_ENTRIES are dropped,
// stored = 0). Classify returns the lowest valid entry whose red, blue and green
// periods differ from the measurement by less than color_tolerance and whose
// unfiltered period differs by less than white_tolerance. Every request gives
// exactly one result. The table is a row of NUM_ENTRIES cells, one entry each;
// a request enters cell 0 at its accept edge and moves one cell per clock; a new
// request is taken only once the previous one has left the row and any parked
// result has moved to the output register. A finished result waits in an output
// register while the next request is already walking the row; a second finished
// result is parked until the first is taken. Register writes are always ready;
// write them only while no request is in flight. Entries are invalid after reset.
module color_window_classifier
    import cwc_pkg::*;
#(
    parameter int NUM_ENTRIES = 10,
    parameter int PERIOD_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    cwc_item_if.sink      item,
    cwc_result_if.source  result,
    cwc_cfg_if.sink       cfg
);

    // configuration registers
    logic [TOL_W-1:0] color_tol_reg;
    logic [TOL_W-1:0] white_tol_reg;

    // control
    cwc_state_t state_reg;
    cwc_state_t state_next;
    logic       item_accept;
    logic       exit_active;
    logic       out_free;
    logic       load_from_row;
    logic       load_from_park;
    logic       park_load;

    // result holding
    logic       out_valid_reg;
    logic       out_valid_next;
    cwc_token_t out_res_reg;
    cwc_token_t park_reg;

    // cell row links
    cwc_token_t                  tok [0:NUM_ENTRIES];
    logic [3:0][PERIOD_BITS-1:0] per [0:NUM_ENTRIES];

    // register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_tol_reg <= COLOR_TOL_RESET;
            white_tol_reg <= WHITE_TOL_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cwc_cfg_addr_t'(cfg.index))
                CFG_COLOR_TOL: color_tol_reg <= cfg.data;
                CFG_WHITE_TOL: white_tol_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // request injection at the head of the row
    assign item_accept = item.valid && item.ready;

    always_comb
    begin
        tok[0].active      = item_accept;
        tok[0].command     = item.command;
        tok[0].entry_index = item.entry_index;
        tok[0].found       = 1'b0;
        tok[0].match_index = '0;
        tok[0].stored      = 1'b0;
        // periods reduced to the stored width on arrival
        per[0][0] = item.red_period[PERIOD_BITS-1:0];
        per[0][1] = item.blue_period[PERIOD_BITS-1:0];
        per[0][2] = item.green_period[PERIOD_BITS-1:0];
        per[0][3] = item.white_period[PERIOD_BITS-1:0];
    end

    // row of entry cells, lowest index first so the first hit wins
    for (genvar g = 0; g < NUM_ENTRIES; g++)
    begin : g_cell
        cwc_cell #(
            .CELL_INDEX  (g),
            .PERIOD_BITS (PERIOD_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .color_tol (color_tol_reg),
            .white_tol (white_tol_reg),
            .tok_in    (tok[g]),
            .per_in    (per[g]),
            .tok_out   (tok[g+1]),
            .per_out   (per[g+1])
        );
    end

    assign exit_active = tok[NUM_ENTRIES].active;
    assign out_free    = !out_valid_reg || result.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (exit_active)
                begin
                    state_next = out_free ? ST_IDLE : ST_PARK;
                end
            end
            ST_PARK:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        item.ready     = 1'b0;
        load_from_row  = 1'b0;
        load_from_park = 1'b0;
        park_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE: item.ready = 1'b1;
            ST_SCAN:
            begin
                load_from_row = exit_active && out_free;
                park_load     = exit_active && !out_free;
            end
            ST_PARK: load_from_park = out_free;
            default: ;
        endcase
    end

    always_comb
    begin
        if (load_from_row || load_from_park)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (park_load)
        begin
            park_reg <= tok[NUM_ENTRIES];
        end
        if (load_from_row)
        begin
            out_res_reg <= tok[NUM_ENTRIES];
        end
        else if (load_from_park)
        begin
            out_res_reg <= park_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.match_found = out_res_reg.found;
    assign result.match_index = out_res_reg.match_index;
    assign result.stored      = out_res_reg.stored;

endmodule

// File: design/cwc_checker.sv
// port level checks of the color window classifier, bound to the top level
module cwc_checker
    import cwc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input logic             res_valid,
    input logic             res_ready,
    input logic             res_match_found,
    input logic [IDX_W-1:0] res_match_index,
    input logic             res_stored
);

    // a result held under back pressure keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_match_found)
            && $stable(res_match_index) && $stable(res_stored))
    else $error("result changed while stalled");

    // a result is either a stored calibration or a classification, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_match_found && res_stored))
    else $error("match and store reported together");

    // no match reports index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_match_found |-> res_match_index == '0)
    else $error("nonzero index without a match");

    // one request in the row at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
    else $error("request taken while another is in flight");

endmodule

bind color_window_classifier cwc_checker u_cwc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .res_match_found (result.match_found),
    .res_match_index (result.match_index),
    .res_stored      (result.stored)
);

// File: tb/testbench.sv
// self-checking testbench of the color window classifier
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cwc_pkg::*;

    // block configuration, kept equal to the instance below
    localparam int NUM_ENTRIES = 10;
    localparam int PERIOD_BITS = 16;
    localparam logic [PERIOD_W-1:0] PERIOD_MASK = PERIOD_W'((1 << PERIOD_BITS) - 1);

    localparam int CLK_HALF         = 4;
    localparam int RESET_CYCLES     = 8;
    localparam int IDLE_PCT         = 22;
    localparam int HOLD_OFF_CYCLES  = 300;
    // settle time after draining, sized from the length of the cell row
    localparam int SETTLE_CYCLES    = 2 * (NUM_ENTRIES + 1);
    localparam int PHASES           = 8;
    localparam int RANDOM_PER_PHASE = 210;
    localparam int CYCLE_LIMIT      = 600000;

    typedef struct packed {
        logic [PERIOD_W-1:0] red;
        logic [PERIOD_W-1:0] blue;
        logic [PERIOD_W-1:0] green;
        logic [PERIOD_W-1:0] white;
    } periods_t;

    typedef struct packed {
        cwc_cmd_t         command;
        logic [IDX_W-1:0] entry_index;
        periods_t         periods;
    } request_t;

    typedef struct packed {
        logic             match_found;
        logic [IDX_W-1:0] match_index;
        logic             stored;
    } outcome_t;

    // kinds of rows in the directed table
    typedef enum logic [0:0] {
        ROW_REQUEST,
        ROW_REGISTER
    } row_kind_t;

    typedef struct {
        row_kind_t        kind;
        request_t         req;
        bit               typed;
        outcome_t         want;
        cwc_cfg_addr_t    reg_addr;
        logic [TOL_W-1:0] reg_value;
    } row_t;

    localparam outcome_t OUT_NONE   = '{1'b0, 4'd0, 1'b0};
    localparam outcome_t OUT_STORED = '{1'b0, 4'd0, 1'b1};

    logic clk;
    logic rst_n;

    cwc_item_if   item_ch ();
    cwc_result_if result_ch ();
    cwc_cfg_if    cfg_ch ();

    color_window_classifier #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .PERIOD_BITS (PERIOD_BITS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // own copy of the calibration table, its valid bits and the tolerances;
    // entries whose valid bit is clear are never looked at
    periods_t               cal_table [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] cal_valid = '0;
    logic [TOL_W-1:0]       color_tol = COLOR_TOL_RESET;
    logic [TOL_W-1:0]       white_tol = WHITE_TOL_RESET;

    // results still owed by the block, oldest first
    outcome_t pending_outcomes [$];
    row_t     directed_rows [$];

    int failures        = 0;
    int hold_offs_asked = 0;
    bit steady          = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // strict window: the gap must stay below the bound, so a zero bound never passes
    function automatic bit near(logic [PERIOD_W-1:0] held, logic [PERIOD_W-1:0] seen,
                                logic [TOL_W-1:0] bound);
        int unsigned gap;
        gap = (held > seen) ? held - seen : seen - held;
        return gap < bound;
    endfunction

    // update the table for a calibrate request, or scan it for a classify request
    function automatic outcome_t classify_or_store(request_t req);
        outcome_t res;
        periods_t p;
        res     = OUT_NONE;
        p.red   = req.periods.red & PERIOD_MASK;
        p.blue  = req.periods.blue & PERIOD_MASK;
        p.green = req.periods.green & PERIOD_MASK;
        p.white = req.periods.white & PERIOD_MASK;
        if (req.command == CMD_CALIBRATE)
        begin
            // indexes past the table are dropped without a trace
            if (req.entry_index < NUM_ENTRIES)
            begin
                cal_table[req.entry_index] = p;
                cal_valid[req.entry_index] = 1'b1;
                res.stored = 1'b1;
            end
            return res;
        end
        // lowest valid entry wins
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (cal_valid[i] &&
                near(cal_table[i].red,   p.red,   color_tol) &&
                near(cal_table[i].blue,  p.blue,  color_tol) &&
                near(cal_table[i].green, p.green, color_tol) &&
                near(cal_table[i].white, p.white, white_tol))
            begin
                res.match_found = 1'b1;
                res.match_index = IDX_W'(i);
                return res;
            end
        end
        return res;
    endfunction

    // random offset of up to one past the bound either way, wrapping at the period width
    function automatic logic [PERIOD_W-1:0] nudge(logic [PERIOD_W-1:0] base,
                                                  logic [TOL_W-1:0] bound);
        int span;
        int offset;
        span   = bound + 1;
        offset = $urandom_range(2 * span) - span;
        return PERIOD_W'(base + offset);
    endfunction

    function automatic int unsigned any_valid_slot();
        int unsigned slot;
        do
            slot = $urandom_range(NUM_ENTRIES - 1);
        while (!cal_valid[slot]);
        return slot;
    endfunction

    // mostly well-formed traffic: calibrations, then measurements close to stored
    // entries so that the window edges get hit; some plain noise on top
    function automatic request_t random_request();
        request_t    req;
        int unsigned pick;
        int unsigned slot;
        req.command     = CMD_CLASSIFY;
        req.entry_index = IDX_W'($urandom_range(15));
        req.periods     = {$urandom, $urandom};
        pick            = $urandom_range(99);
        if (pick < 8)
        begin
            req.command = cwc_cmd_t'($urandom_range(1));
            return req;
        end
        if (pick < 32 || cal_valid == '0)
        begin
            req.command = CMD_CALIBRATE;
            if ($urandom_range(9) != 0)
                req.entry_index = IDX_W'($urandom_range(NUM_ENTRIES - 1));
            if (cal_valid != '0 && $urandom_range(2) == 0)
            begin
                // overlapping entries make the lowest-index rule matter
                slot = any_valid_slot();
                req.periods.red   = nudge(cal_table[slot].red,   color_tol);
                req.periods.blue  = nudge(cal_table[slot].blue,  color_tol);
                req.periods.green = nudge(cal_table[slot].green, color_tol);
                req.periods.white = nudge(cal_table[slot].white, white_tol);
            end
            else if ($urandom_range(9) == 0)
            begin
                req.periods.red   = $urandom_range(1) ? '1 : '0;
                req.periods.blue  = $urandom_range(1) ? '1 : '0;
                req.periods.green = $urandom_range(1) ? '1 : '0;
                req.periods.white = $urandom_range(1) ? '1 : '0;
            end
            return req;
        end
        slot = any_valid_slot();
        req.periods.red   = nudge(cal_table[slot].red,   color_tol);
        req.periods.blue  = nudge(cal_table[slot].blue,  color_tol);
        req.periods.green = nudge(cal_table[slot].green, color_tol);
        req.periods.white = nudge(cal_table[slot].white, white_tol);
        // now and then one channel is way off
        if ($urandom_range(6) == 0)
        begin
            case ($urandom_range(3))
                0: req.periods.red   = $urandom;
                1: req.periods.blue  = $urandom;
                2: req.periods.green = $urandom;
                default: req.periods.white = $urandom;
            endcase
        end
        return req;
    endfunction

    // offer one request, maybe after a random gap; the expectation is booked at
    // the accepting edge, either typed in by the caller or from the predictor
    task automatic offer_request(request_t req, bit typed, outcome_t want);
        outcome_t predicted;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.command      <= req.command;
        item_ch.entry_index  <= req.entry_index;
        item_ch.red_period   <= req.periods.red;
        item_ch.blue_period  <= req.periods.blue;
        item_ch.green_period <= req.periods.green;
        item_ch.white_period <= req.periods.white;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        predicted = classify_or_store(req);
        pending_outcomes.push_back(typed ? want : predicted);
    endtask

    // stop offering and wait until every owed result is back, then a little more
    task automatic wait_until_drained();
        item_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // tolerance writes only land on an idle block
    task automatic write_register(cwc_cfg_addr_t addr, logic [TOL_W-1:0] value);
        wait_until_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= addr;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (addr == CFG_COLOR_TOL)
            color_tol = value;
        else
            white_tol = value;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void add_request(cwc_cmd_t command, int idx, periods_t p, bit typed,
                                        outcome_t want);
        row_t row;
        row.kind      = ROW_REQUEST;
        row.req       = '{command, IDX_W'(idx), p};
        row.typed     = typed;
        row.want      = want;
        row.reg_addr  = CFG_COLOR_TOL;
        row.reg_value = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_register(cwc_cfg_addr_t addr, logic [TOL_W-1:0] value);
        row_t row;
        row.kind      = ROW_REGISTER;
        row.req       = '0;
        row.typed     = 1'b0;
        row.want      = OUT_NONE;
        row.reg_addr  = addr;
        row.reg_value = value;
        directed_rows.push_back(row);
    endfunction

    // result side: random back-pressure, long hold-offs on demand, in-order checking
    initial
    begin : result_sink
        int unsigned stall_left;
        int          stalls_seen;
        outcome_t    want;
        stall_left = 0;
        stalls_seen = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $error("unexpected result: match_found %0d match_index %0d stored %0d",
                           result_ch.match_found, result_ch.match_index, result_ch.stored);
                    failures++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (result_ch.match_found !== want.match_found)
                    begin
                        $error("match_found: expected %0d, got %0d",
                               want.match_found, result_ch.match_found);
                        failures++;
                    end
                    if (result_ch.match_index !== want.match_index)
                    begin
                        $error("match_index: expected %0d, got %0d",
                               want.match_index, result_ch.match_index);
                        failures++;
                    end
                    if (result_ch.stored !== want.stored)
                    begin
                        $error("stored: expected %0d, got %0d", want.stored, result_ch.stored);
                        failures++;
                    end
                end
            end
            // a new hold-off request restarts the count here
            if (hold_offs_asked != stalls_seen)
            begin
                stalls_seen = hold_offs_asked;
                stall_left  = HOLD_OFF_CYCLES;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // hard stop if the block hangs
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        logic [TOL_W-1:0] c_tol;
        logic [TOL_W-1:0] w_tol;

        rst_n                <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.command      <= CMD_CLASSIFY;
        item_ch.entry_index  <= '0;
        item_ch.red_period   <= '0;
        item_ch.blue_period  <= '0;
        item_ch.green_period <= '0;
        item_ch.white_period <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= CFG_COLOR_TOL;
        cfg_ch.data          <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset tolerances: color 5, white 2
        // nothing calibrated yet, so nothing can match
        add_request(CMD_CLASSIFY, 0, '0, 1'b1, OUT_NONE);
        add_request(CMD_CLASSIFY, 15, '1, 1'b1, OUT_NONE);
        // out-of-range calibrations are dropped
        add_request(CMD_CALIBRATE, 15, '1, 1'b1, OUT_NONE);
        add_request(CMD_CALIBRATE, NUM_ENTRIES, '1, 1'b1, OUT_NONE);
        // first and last entry at the period extremes
        add_request(CMD_CALIBRATE, 0, '0, 1'b1, OUT_STORED);
        add_request(CMD_CALIBRATE, NUM_ENTRIES - 1, '1, 1'b1, OUT_STORED);
        add_request(CMD_CLASSIFY, 0, '0, 1'b1, '{1'b1, 4'd0, 1'b0});
        add_request(CMD_CLASSIFY, 0, '1, 1'b1, '{1'b1, 4'(NUM_ENTRIES - 1), 1'b0});
        // window edges: inside by one, then exactly on the bound
        add_request(CMD_CLASSIFY, 0, {16'd4, 16'd0, 16'd0, 16'd0}, 1'b0, OUT_NONE);
        add_request(CMD_CLASSIFY, 0, {16'd5, 16'd0, 16'd0, 16'd0}, 1'b0, OUT_NONE);
        add_request(CMD_CLASSIFY, 0, {16'd0, 16'd0, 16'd0, 16'd1}, 1'b0, OUT_NONE);
        add_request(CMD_CLASSIFY, 0, {16'd0, 16'd0, 16'd0, 16'd2}, 1'b0, OUT_NONE);
        add_request(CMD_CLASSIFY, 0, {16'hffff, 16'hfffb, 16'hffff, 16'hfffe}, 1'b0, OUT_NONE);
        // alternating bit patterns
        add_request(CMD_CALIBRATE, 3, {16'ha5a5, 16'h5a5a, 16'h3c3c, 16'hc3c3}, 1'b1,
                    OUT_STORED);
        add_request(CMD_CLASSIFY, 7, {16'ha5a1, 16'h5a5e, 16'h3c3c, 16'hc3c4}, 1'b0, OUT_NONE);
        // duplicate entry: the lower index must win
        add_request(CMD_CALIBRATE, 1, '0, 1'b1, OUT_STORED);
        add_request(CMD_CLASSIFY, 0, '0, 1'b0, OUT_NONE);
        // overwrite entry 0, entry 1 takes over
        add_request(CMD_CALIBRATE, 0, {16'h1234, 16'h5678, 16'h9abc, 16'hdef0}, 1'b1,
                    OUT_STORED);
        add_request(CMD_CLASSIFY, 0, {16'd2, 16'd2, 16'd2, 16'd1}, 1'b0, OUT_NONE);
        // zero color tolerance never matches
        add_register(CFG_COLOR_TOL, 8'd0);
        add_request(CMD_CLASSIFY, 0, '0, 1'b1, OUT_NONE);
        // widest color window, zero white window
        add_register(CFG_COLOR_TOL, 8'd255);
        add_register(CFG_WHITE_TOL, 8'd0);
        add_request(CMD_CLASSIFY, 0, '0, 1'b1, OUT_NONE);
        add_register(CFG_WHITE_TOL, 8'd255);
        add_request(CMD_CLASSIFY, 0, {16'd254, 16'd254, 16'd254, 16'd254}, 1'b0, OUT_NONE);
        add_request(CMD_CLASSIFY, 0, {16'd255, 16'd0, 16'd0, 16'd0}, 1'b0, OUT_NONE);

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_REGISTER)
                write_register(directed_rows[k].reg_addr, directed_rows[k].reg_value);
            else
                offer_request(directed_rows[k].req, directed_rows[k].typed,
                              directed_rows[k].want);
        end

        // random part, one tolerance setting per phase
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin c_tol = COLOR_TOL_RESET; w_tol = WHITE_TOL_RESET; end
                1: begin c_tol = 8'd0;   w_tol = 8'd0;   end
                2: begin c_tol = 8'd255; w_tol = 8'd255; end
                3: begin c_tol = 8'd1;   w_tol = 8'd1;   end
                4: begin c_tol = 8'd255; w_tol = 8'd0;   end
                5: begin c_tol = 8'd0;   w_tol = 8'd255; end
                default:
                begin
                    c_tol = TOL_W'($urandom_range(1, 40));
                    w_tol = TOL_W'($urandom_range(1, 20));
                end
            endcase
            write_register(CFG_COLOR_TOL, c_tol);
            write_register(CFG_WHITE_TOL, w_tol);
            // one phase runs flat out on both sides
            steady = (phase == 3);
            // long receiver hold-off while requests keep coming
            if (phase == 2 || phase == 6)
                hold_offs_asked <= hold_offs_asked + 1;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // sender pauses halfway until the block has emptied
                if (n == RANDOM_PER_PHASE / 2)
                    wait_until_drained();
                offer_request(random_request(), 1'b0, OUT_NONE);
            end
        end
        steady = 1'b0;

        wait_until_drained();
        if (failures == 0 && pending_outcomes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
design/cwc_pkg.sv
design/cwc_if.sv
design/cwc_cell.sv
design/color_window_classifier.sv
design/cwc_checker.sv
tb/testbench.sv
